// File: rtl/cpp_pkg.sv
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared types and constants of the command packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cpp_pkg;

    localparam int WORD_W    = 32;
    localparam int LEFT_W    = 20;
    localparam int ACT_W     = 3;
    localparam int REG_W     = 16;
    localparam int IBW_W     = 20;
    localparam int CNT_W     = 15;
    localparam int MODE_W    = 4;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 1;
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 72;

    localparam logic [ACT_W-1:0] ACT_NONE     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_REG_WR   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_IB_REQ   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_INIT     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_OVERFLOW = 3'd4;
    localparam logic [ACT_W-1:0] ACT_BAD_OP   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_BIN_SELECT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_MASK   = 1'd1;

    localparam logic [6:0] OP_NOP     = 7'h10;
    localparam logic [6:0] OP_ME_INIT = 7'h48;
    localparam logic [6:0] OP_IB      = 7'h3F;
    localparam logic [6:0] OP_IB_PFD  = 7'h37;

    localparam logic [1:0] PKT_TYPE0 = 2'd0;
    localparam logic [1:0] PKT_TYPE1 = 2'd1;
    localparam logic [1:0] PKT_TYPE3 = 2'd3;

    localparam logic [WORD_W-1:0] FILL_WORD = 32'hCDCDCDCD;

    typedef struct packed {
        logic [IBW_W-1:0]  ib_words;
        logic [WORD_W-1:0] value;
        logic [REG_W-1:0]  reg_index;
        logic [ACT_W-1:0]  action;
    } result_t;

    function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/cpp_in_stage.sv
// ----------------------------------------------------------------------------
// cpp_in_stage
// Input register for command beats.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_in_stage (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [cpp_pkg::WORD_W-1:0]  s_word,
    input  wire logic [cpp_pkg::LEFT_W-1:0]  s_left,
    input  wire logic                        adv,
    output logic                             vld,
    output logic [cpp_pkg::WORD_W-1:0]       word,
    output logic [cpp_pkg::LEFT_W-1:0]       left
);

    logic                       vld_reg;
    logic                       vld_next;
    logic [cpp_pkg::WORD_W-1:0] word_reg;
    logic [cpp_pkg::LEFT_W-1:0] left_reg;
    logic                       take;

    assign s_tready = !vld_reg || adv;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        vld_next = vld_reg;
        if (take) begin
            vld_next = 1'b1;
        end else if (adv) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            word_reg <= s_word;
            left_reg <= s_left;
        end
    end

    assign vld  = vld_reg;
    assign word = word_reg;
    assign left = left_reg;

endmodule

`default_nettype wire

// File: rtl/cpp_core.sv
// ----------------------------------------------------------------------------
// cpp_core
// Packet state machine: header decode and per-word result generation.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       fire,
    input  wire logic [cpp_pkg::WORD_W-1:0] raw_word,
    input  wire logic [cpp_pkg::LEFT_W-1:0] left,
    input  wire logic [cpp_pkg::CFG_W-1:0]  bin_select,
    input  wire logic [cpp_pkg::CFG_W-1:0]  bin_mask,
    output cpp_pkg::result_t                res
);

    localparam logic [cpp_pkg::MODE_W-1:0] MODE_HEADER = 4'd0;
    localparam logic [cpp_pkg::MODE_W-1:0] MODE_T0     = 4'd1;
    localparam logic [cpp_pkg::MODE_W-1:0] MODE_T1A    = 4'd2;
    localparam logic [cpp_pkg::MODE_W-1:0] MODE_T1B    = 4'd3;
    localparam logic [cpp_pkg::MODE_W-1:0] MODE_SKIP   = 4'd4;
    localparam logic [cpp_pkg::MODE_W-1:0] MODE_INIT   = 4'd5;
    localparam logic [cpp_pkg::MODE_W-1:0] MODE_IBADDR = 4'd6;
    localparam logic [cpp_pkg::MODE_W-1:0] MODE_IBSIZE = 4'd7;
    localparam logic [cpp_pkg::MODE_W-1:0] MODE_FLUSH  = 4'd8;

    logic [cpp_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [cpp_pkg::CNT_W-1:0]  wtg_reg, wtg_next;
    logic [cpp_pkg::REG_W-1:0]  nreg_reg, nreg_next;
    logic                       same_reg, same_next;
    logic [10:0]                sreg_reg, sreg_next;
    logic [cpp_pkg::WORD_W-1:0] addr_reg, addr_next;

    logic [cpp_pkg::WORD_W-1:0] w;
    logic [1:0]                 ptype;
    logic [cpp_pkg::CNT_W-1:0]  cnt;
    logic [cpp_pkg::CNT_W-1:0]  wtg_dec;
    logic                       too_long;
    logic [6:0]                 op;
    logic                       pred_fail;
    logic [cpp_pkg::MODE_W-1:0] flush_mode;

    assign w          = cpp_pkg::swap32(raw_word);
    assign ptype      = w[31:30];
    assign cnt        = {1'b0, w[29:16]} + 15'd1;
    assign wtg_dec    = wtg_reg - 15'd1;
    assign too_long   = left < {5'd0, cnt};
    assign op         = w[14:8];
    assign pred_fail  = w[0] && ((bin_select & bin_mask) == '0);
    assign flush_mode = (left != '0) ? MODE_FLUSH : MODE_HEADER;

    always_comb begin
        mode_next = mode_reg;
        wtg_next  = wtg_reg;
        nreg_next = nreg_reg;
        same_next = same_reg;
        sreg_next = sreg_reg;
        addr_next = addr_reg;
        res       = '0;
        case (mode_reg)
            MODE_T0: begin
                res.action    = cpp_pkg::ACT_REG_WR;
                res.reg_index = nreg_reg;
                res.value     = w;
                if (!same_reg) begin
                    nreg_next = nreg_reg + 16'd1;
                end
                wtg_next = wtg_dec;
                if (wtg_dec == '0) begin
                    mode_next = MODE_HEADER;
                end
            end
            MODE_T1A: begin
                res.action    = cpp_pkg::ACT_REG_WR;
                res.reg_index = nreg_reg;
                res.value     = w;
                mode_next     = MODE_T1B;
            end
            MODE_T1B: begin
                res.action    = cpp_pkg::ACT_REG_WR;
                res.reg_index = {5'd0, sreg_reg};
                res.value     = w;
                mode_next     = MODE_HEADER;
            end
            MODE_SKIP: begin
                wtg_next = wtg_dec;
                if (wtg_dec == '0) begin
                    mode_next = MODE_HEADER;
                end
            end
            MODE_INIT: begin
                res.action    = cpp_pkg::ACT_INIT;
                res.reg_index = nreg_reg;
                res.value     = w;
                nreg_next     = nreg_reg + 16'd1;
                wtg_next      = wtg_dec;
                if (wtg_dec == '0) begin
                    mode_next = MODE_HEADER;
                end
            end
            MODE_IBADDR: begin
                addr_next = w;
                wtg_next  = wtg_dec;
                mode_next = (wtg_dec == '0) ? MODE_HEADER : MODE_IBSIZE;
            end
            MODE_IBSIZE: begin
                res.action   = cpp_pkg::ACT_IB_REQ;
                res.value    = addr_reg;
                res.ib_words = w[19:0];
                wtg_next     = wtg_dec;
                mode_next    = (wtg_dec == '0) ? MODE_HEADER : MODE_SKIP;
            end
            MODE_FLUSH: begin
                if (left == '0) begin
                    mode_next = MODE_HEADER;
                end
            end
            default: begin
                mode_next = MODE_HEADER;
                if (w != '0 && w != cpp_pkg::FILL_WORD) begin
                    case (ptype)
                        cpp_pkg::PKT_TYPE0: begin
                            if (too_long) begin
                                res.action = cpp_pkg::ACT_OVERFLOW;
                                mode_next  = flush_mode;
                            end else begin
                                wtg_next  = cnt;
                                nreg_next = {1'b0, w[14:0]};
                                same_next = w[15];
                                mode_next = MODE_T0;
                            end
                        end
                        cpp_pkg::PKT_TYPE1: begin
                            if (left < 20'd2) begin
                                res.action = cpp_pkg::ACT_OVERFLOW;
                                mode_next  = flush_mode;
                            end else begin
                                nreg_next = {5'd0, w[10:0]};
                                sreg_next = w[21:11];
                                mode_next = MODE_T1A;
                            end
                        end
                        cpp_pkg::PKT_TYPE3: begin
                            if (too_long) begin
                                res.action = cpp_pkg::ACT_OVERFLOW;
                                mode_next  = flush_mode;
                            end else begin
                                wtg_next = cnt;
                                if (pred_fail || op == cpp_pkg::OP_NOP) begin
                                    mode_next = MODE_SKIP;
                                end else if (op == cpp_pkg::OP_ME_INIT) begin
                                    nreg_next = '0;
                                    mode_next = MODE_INIT;
                                end else if ((op == cpp_pkg::OP_IB ||
                                              op == cpp_pkg::OP_IB_PFD) &&
                                             cnt >= 15'd2) begin
                                    mode_next = MODE_IBADDR;
                                end else begin
                                    wtg_next   = '0;
                                    res.action = cpp_pkg::ACT_BAD_OP;
                                    mode_next  = flush_mode;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_HEADER;
            wtg_reg  <= '0;
            nreg_reg <= '0;
            same_reg <= 1'b0;
            sreg_reg <= '0;
            addr_reg <= '0;
        end else if (fire) begin
            mode_reg <= mode_next;
            wtg_reg  <= wtg_next;
            nreg_reg <= nreg_next;
            same_reg <= same_next;
            sreg_reg <= sreg_next;
            addr_reg <= addr_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/cpp_out_stage.sv
// ----------------------------------------------------------------------------
// cpp_out_stage
// Result register driving the master-side stream.
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_out_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_vld,
    input  wire cpp_pkg::result_t in_res,
    output logic                  adv,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output cpp_pkg::result_t      m_res
);

    logic             vld_reg;
    logic             vld_next;
    cpp_pkg::result_t res_reg;
    logic             load;

    assign adv  = !vld_reg || m_tready;
    assign load = adv && in_vld;

    always_comb begin
        vld_next = vld_reg;
        if (adv) begin
            vld_next = in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= in_res;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_res    = res_reg;

endmodule

`default_nettype wire

// File: rtl/gpu_command_packet_parser.sv
// ----------------------------------------------------------------------------
// gpu_command_packet_parser
// Each accepted beat passes through the input register, the combinational
// decode and the result register, which drives m_tvalid. Throughput: one
// command word per cycle while m_tready does not stall the result register.
// Reset (aresetn low, synchronous): parser returns to header, all packet state
// and both bin registers clear, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module gpu_command_packet_parser (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [31:0] cmd_word, [51:32] words_left, [55:52] zero
    input  wire logic [cpp_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [2:0] action, [18:3] reg_index, [50:19] value, [70:51] ib_words, [71] zero
    output logic [cpp_pkg::M_DATA_W-1:0]          m_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cpp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cpp_pkg::CFG_W-1:0]        cfg_data
);

    logic [cpp_pkg::CFG_W-1:0]  bin_select_reg;
    logic [cpp_pkg::CFG_W-1:0]  bin_mask_reg;
    logic                       adv;
    logic                       in_vld;
    logic [cpp_pkg::WORD_W-1:0] in_word;
    logic [cpp_pkg::LEFT_W-1:0] in_left;
    cpp_pkg::result_t           core_res;
    cpp_pkg::result_t           out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_select_reg <= '0;
            bin_mask_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                cpp_pkg::CFG_BIN_SELECT: bin_select_reg <= cfg_data;
                cpp_pkg::CFG_BIN_MASK:   bin_mask_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    cpp_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_word   (s_tdata[31:0]),
        .s_left   (s_tdata[51:32]),
        .adv      (adv),
        .vld      (in_vld),
        .word     (in_word),
        .left     (in_left)
    );

    cpp_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (in_vld && adv),
        .raw_word   (in_word),
        .left       (in_left),
        .bin_select (bin_select_reg),
        .bin_mask   (bin_mask_reg),
        .res        (core_res)
    );

    cpp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_vld   (in_vld),
        .in_res   (core_res),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (out_res)
    );

    assign m_tdata = {1'b0, out_res};

    a_action_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_res.action <= cpp_pkg::ACT_BAD_OP))
        else $error("action code out of range");

    a_ib_words_only_ib: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res.action != cpp_pkg::ACT_IB_REQ) |-> (out_res.ib_words == '0))
        else $error("ib_words set on a non-indirect result");

    a_index_only_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res.action != cpp_pkg::ACT_REG_WR &&
         out_res.action != cpp_pkg::ACT_INIT) |-> (out_res.reg_index == '0))
        else $error("reg_index set on a result without an index");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && !in_vld))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
